/* sv/tcm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_pkg: shared types and constants of the transaction contention manager
// Field widths, operation and register codes, controller states and the
// status word of the remainder unit.
// ----------------------------------------------------------------------------
package tcm_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned THREAD_W    = 7;
  localparam int unsigned DRAW_W      = 31;
  localparam int unsigned STAMP_OUT_W = 32;
  localparam int unsigned WCOUNT_W    = 16;
  localparam int unsigned ACOUNT_W    = 8;
  localparam int unsigned BACKOFF_W   = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // remainder unit: dividend padded to an even width, two bits per cycle
  localparam int unsigned DIV_NUM_W   = DRAW_W + 1;
  localparam int unsigned DIV_STEPS   = DIV_NUM_W / 2;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [WCOUNT_W-1:0]   WCOUNT_MAX    = '1;
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = 16'd4;
  localparam logic [ACOUNT_W-1:0]   LIMIT_RST     = 8'd8;
  localparam logic [CFG_DATA_W-1:0] WMULT_RST     = 16'd64;

  typedef enum logic [OP_W-1:0] {
    OP_START    = 2'd0,
    OP_WRITE    = 2'd1,
    OP_ROLLBACK = 2'd2,
    OP_PROBE    = 2'd3
  } tcm_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_ABORT_LIMIT = 2'd1,
    CFG_WAIT_MULT   = 2'd2
  } tcm_cfg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_OUT
  } tcm_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } tcm_div_status_t;

endpackage
`default_nettype wire

/* sv/tcm_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_table: per-thread state memory
// Single-port-write, registered-read memory with a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module tcm_table #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned DATA_W = 57,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              init_done_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;
  logic              clearing_q, clearing_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic              we;
  logic [AW-1:0]     wa;
  logic [DATA_W-1:0] wd;

  always_comb begin
    clearing_d = clearing_q;
    ptr_d      = ptr_q;
    if (clearing_q) begin
      ptr_d = ptr_q + AW'(1);
      if (ptr_q == AW'(DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      ptr_q      <= '0;
    end else begin
      clearing_q <= clearing_d;
      ptr_q      <= ptr_d;
    end
  end

  // sweep zeros through every entry before the first access
  assign we = clearing_q | wr_en_i;
  assign wa = clearing_q ? ptr_q : wr_addr_i;
  assign wd = clearing_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o   = rd_data_q;
  assign init_done_o = ~clearing_q;

endmodule
`default_nettype wire

/* sv/tcm_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_divider: iterative remainder unit
// Restoring division, two quotient bits per cycle; a zero divisor gives 0.
// ----------------------------------------------------------------------------
module tcm_divider import tcm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DRAW_W-1:0]    dividend_i,
  input  logic [BACKOFF_W-1:0] divisor_i,
  output tcm_div_status_t      status_o,
  output logic [BACKOFF_W-1:0] rem_o
);

  logic                 active_q, active_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [BACKOFF_W-1:0] rem_q, rem_d;
  logic [BACKOFF_W-1:0] dvs_q, dvs_d;
  logic [BACKOFF_W-1:0] rem_mid;

  function automatic logic [BACKOFF_W-1:0] rem_step(input logic [BACKOFF_W-1:0] r,
                                                     input logic                 b,
                                                     input logic [BACKOFF_W-1:0] d);
    logic [BACKOFF_W:0] sh;
    sh = {r, b};
    if (sh >= {1'b0, d}) begin
      sh = sh - {1'b0, d};
    end
    return sh[BACKOFF_W-1:0];
  endfunction

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    num_d    = num_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    rem_mid  = rem_step(rem_q, num_q[DIV_NUM_W-1], dvs_q);
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      num_d    = {1'b0, dividend_i};
      rem_d    = '0;
      dvs_d    = divisor_i;
    end else if (active_q) begin
      rem_d = rem_step(rem_mid, num_q[DIV_NUM_W-2], dvs_q);
      num_d = num_q << 2;
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = active_q;
  assign status_o.done = done_q;
  assign rem_o         = (dvs_q == '0) ? '0 : rem_q;

endmodule
`default_nettype wire

/* sv/transaction_contention_manager.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// transaction_contention_manager: per-thread contention manager
// Tracks write counts, abort counts and priority timestamps per thread and
// computes a randomized backoff on rollback.
// ----------------------------------------------------------------------------
// After reset the block sweeps zeros through its thread table with busy_o high;
// configuration writes are taken during that time.
// One word is worked on at a time: a word is taken when start_i is high and
// busy_o is low, and its result shows on result_valid_o for one cycle, which
// the receiver must take then. Start, write and probe words show their result
// after the table read and the modify step (probes write nothing back); an
// in-range rollback also waits on the remainder unit, which resolves two bits
// of the 32-bit padded draw per cycle. busy_o drops the cycle after the strobe.
// ----------------------------------------------------------------------------
module transaction_contention_manager import tcm_pkg::*; #(
  parameter int unsigned THREADS     = 128,
  parameter int unsigned STAMP_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [OP_W-1:0]        opcode_i,
  input  logic [THREAD_W-1:0]    thread_i,
  input  logic                   restarted_i,
  input  logic [DRAW_W-1:0]      random_draw_i,
  output logic                   result_valid_o,
  output logic                   has_timestamp_o,
  output logic [STAMP_OUT_W-1:0] timestamp_o,
  output logic                   newly_assigned_o,
  output logic [ACOUNT_W-1:0]    abort_total_o,
  output logic [BACKOFF_W-1:0]   backoff_cycles_o
);

  localparam int unsigned IDX_W   = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int unsigned ENTRY_W = 1 + STAMP_WIDTH + WCOUNT_W + ACOUNT_W;

  tcm_state_e state_q, state_d;

  logic [CFG_DATA_W-1:0]  thresh_q;
  logic [ACOUNT_W-1:0]    limit_q;
  logic [CFG_DATA_W-1:0]  wmult_q;
  logic [STAMP_WIDTH-1:0] prio_q;

  logic                   accept;
  logic [OP_W-1:0]        op_q;
  logic [IDX_W-1:0]       addr_q;
  logic                   inrange_q;
  logic                   restarted_q;
  logic [DRAW_W-1:0]      draw_q;
  logic                   update;
  logic                   div_start;

  logic [ENTRY_W-1:0]     rd_entry;
  logic [ENTRY_W-1:0]     wr_entry;
  logic                   init_done;
  logic                   ent_valid;
  logic [STAMP_WIDTH-1:0] ent_stamp;
  logic [WCOUNT_W-1:0]    ent_wc;
  logic [ACOUNT_W-1:0]    ent_ac;
  logic                   new_valid;
  logic [STAMP_WIDTH-1:0] new_stamp;
  logic [WCOUNT_W-1:0]    new_wc;
  logic [ACOUNT_W-1:0]    new_ac;
  logic                   newly;
  logic [BACKOFF_W-1:0]   divisor;
  logic [63:0]            stamp_ext;

  tcm_div_status_t        div_status;
  logic [BACKOFF_W-1:0]   div_rem;

  logic                   has_ts_q;
  logic [STAMP_OUT_W-1:0] ts_q;
  logic                   newly_q;
  logic [ACOUNT_W-1:0]    abort_q;
  logic [BACKOFF_W-1:0]   backoff_q;

  assign accept = start_i & ~busy_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESHOLD_RST;
      limit_q  <= LIMIT_RST;
      wmult_q  <= WMULT_RST;
    end else if (cfg_we_i) begin
      case (tcm_cfg_e'(cfg_idx_i))
        CFG_THRESHOLD:   thresh_q <= cfg_wdata_i;
        CFG_ABORT_LIMIT: limit_q  <= cfg_wdata_i[ACOUNT_W-1:0];
        CFG_WAIT_MULT:   wmult_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // capture the word at acceptance; the table read goes out at the same edge
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q        <= opcode_i;
      addr_q      <= IDX_W'(thread_i);
      inrange_q   <= 32'(thread_i) < 32'(THREADS);
      restarted_q <= restarted_i;
      draw_q      <= random_draw_i;
    end
  end

  tcm_table #(
    .DEPTH  (THREADS),
    .DATA_W (ENTRY_W)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_i   (IDX_W'(thread_i)),
    .rd_data_o   (rd_entry),
    .wr_en_i     (update),
    .wr_addr_i   (addr_q),
    .wr_data_i   (wr_entry),
    .init_done_o (init_done)
  );

  // modify the entry read back
  always_comb begin
    {ent_valid, ent_stamp, ent_wc, ent_ac} = rd_entry;
    new_valid = ent_valid;
    new_stamp = ent_stamp;
    new_wc    = ent_wc;
    new_ac    = ent_ac;
    newly     = 1'b0;
    case (tcm_op_e'(op_q))
      OP_START: begin
        new_valid = 1'b0;
        new_stamp = '0;
        new_wc    = '0;
        if (!restarted_q) begin
          new_ac = '0;
        end
      end
      OP_WRITE: begin
        if (ent_wc != WCOUNT_MAX) begin
          new_wc = ent_wc + WCOUNT_W'(1);
        end
        if (!ent_valid && new_wc == thresh_q) begin
          new_valid = 1'b1;
          new_stamp = prio_q;
          newly     = 1'b1;
        end
      end
      OP_ROLLBACK: begin
        if (ent_ac < limit_q) begin
          new_ac = ent_ac + ACOUNT_W'(1);
        end
      end
      default: ;
    endcase
    wr_entry  = {new_valid, new_stamp, new_wc, new_ac};
    divisor   = BACKOFF_W'(BACKOFF_W'(new_ac) * BACKOFF_W'(wmult_q));
    stamp_ext = 64'(new_stamp);
  end

  assign update = (state_q == ST_READ) && inrange_q && (op_q != OP_PROBE);

  // global priority counter, wraps at STAMP_WIDTH bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q <= '0;
    end else if (update && newly) begin
      prio_q <= prio_q + STAMP_WIDTH'(1);
    end
  end

  tcm_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (draw_q),
    .divisor_i  (divisor),
    .status_o   (div_status),
    .rem_o      (div_rem)
  );

  // result word
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      has_ts_q  <= inrange_q & new_valid;
      ts_q      <= (inrange_q && new_valid) ? stamp_ext[STAMP_OUT_W-1:0] : '0;
      newly_q   <= inrange_q & newly;
      abort_q   <= inrange_q ? new_ac : '0;
      backoff_q <= '0;
    end else if (state_q == ST_DIV && div_status.done) begin
      backoff_q <= div_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    busy_o         = 1'b1;
    div_start      = 1'b0;
    result_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (init_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (inrange_q && op_q == OP_ROLLBACK) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        result_valid_o = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign has_timestamp_o  = has_ts_q;
  assign timestamp_o      = ts_q;
  assign newly_assigned_o = newly_q;
  assign abort_total_o    = abort_q;
  assign backoff_cycles_o = backoff_q;

`ifndef SYNTHESIS
  a_strobe_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe outside of a busy period");

  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_backoff_needs_abort : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && backoff_cycles_o != '0) |-> (abort_total_o != '0))
    else $error("nonzero backoff with zero abort count");

  a_newly_has_stamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && newly_assigned_o) |-> has_timestamp_o)
    else $error("timestamp assigned but not reported as held");

  a_div_only_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_status.done |-> (state_q == ST_DIV))
    else $error("remainder finished outside of the wait state");
`endif

endmodule
`default_nettype wire
